/* hdl/calendar_date_day_offset_top_assert.svh */
// Assertion macros shared by the date offset RTL files
`ifndef CALENDAR_DATE_DAY_OFFSET_TOP_ASSERT_SVH
`define CALENDAR_DATE_DAY_OFFSET_TOP_ASSERT_SVH

// Checked property, quiet while reset is asserted
`define CDO_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property that also holds during reset
`define CDO_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/cdo_pkg.sv */
// Types, constants and calendar helper functions for the date offset block
package cdo_pkg;

  // Calendar constants
  localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;
  localparam logic [4:0] FEB_DAYS      = 5'd28;
  localparam logic [4:0] LONG_DAYS     = 5'd31;
  localparam logic [4:0] SHORT_DAYS    = 5'd30;
  localparam logic [3:0] MONTH_JAN     = 4'd1;
  localparam logic [3:0] MONTH_FEB     = 4'd2;
  localparam logic [3:0] MONTH_DEC     = 4'd12;

  // Gregorian cycle used for the leap rule
  localparam int         YEAR_CYCLE    = 400;
  localparam int         CENTURY       = 100;
  localparam logic [8:0] CYCLE_LAST    = 9'(YEAR_CYCLE - 1);

  // Year reduction: start year is 14 bits, 400 << 5 is the top trial value
  localparam int         YEAR_W        = 14;
  localparam logic [2:0] MOD_TOP_SHIFT = 3'd5;

  typedef struct packed {
    logic        mode;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [13:0] start_year;
    logic [15:0] offset_days;
  } in_t;

  typedef struct packed {
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic        out_of_range;
    logic        bad_input;
  } out_t;

  // Control outcome of one month step
  typedef struct packed {
    logic finish;
    logic year_inc;
    logic year_dec;
  } step_ctl_t;

  // Leap rule from the year modulo 400
  function automatic logic leap_of(input logic [8:0] r);
    logic div4;
    logic cent;
    div4 = (r[1:0] == 2'd0);
    cent = (r == 9'(CENTURY)) || (r == 9'(2 * CENTURY)) || (r == 9'(3 * CENTURY));
    return div4 && !cent;
  endfunction

  // Days in month m; months outside 1..12 read as 31
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = LONG_DAYS;
    case (m) inside
      MONTH_FEB:                   len = leap ? FEB_LEAP_DAYS : FEB_DAYS;
      4'd4, 4'd6, 4'd9, 4'd11:     len = SHORT_DAYS;
      default:                     len = LONG_DAYS;
    endcase
    return len;
  endfunction

endpackage

/* hdl/cdo_year_mod.sv */
// Iterative reduction of the start year modulo 400 (restoring, one trial per cycle)
`include "calendar_date_day_offset_top_assert.svh"

module cdo_year_mod (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       go_i,
  input  logic [cdo_pkg::YEAR_W-1:0] year_i,
  output logic                       done_o,
  output logic [8:0]                 rem_o
);

  logic [cdo_pkg::YEAR_W-1:0] rem_q, rem_d;
  logic [2:0]                 cnt_q, cnt_d;
  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic [cdo_pkg::YEAR_W:0]   trial;

  // Trial subtrahend 400 << cnt
  assign trial = (cdo_pkg::YEAR_W + 1)'(cdo_pkg::YEAR_CYCLE) << cnt_q;

  always_comb begin
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (go_i) begin
      rem_d = year_i;
      cnt_d = cdo_pkg::MOD_TOP_SHIFT;
      run_d = 1'b1;
    end else if (run_q) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = rem_q - cdo_pkg::YEAR_W'(trial);
      end
      if (cnt_q == 3'd0) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[8:0];

  `CDO_ASSERT(a_rem_reduced, done_q |-> (rem_q < cdo_pkg::YEAR_W'(cdo_pkg::YEAR_CYCLE)), "year remainder not below 400")
  `CDO_ASSERT(a_done_after_run, done_q |-> $past(run_q), "reduction done without running")

endmodule

/* hdl/cdo_step.sv */
// One month step of the date walk: shared add/compare/subtract unit
module cdo_step #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                    mode_i,
  input  logic [4:0]              day_i,
  input  logic [3:0]              month_i,
  input  logic [8:0]              rem_i,
  input  logic [OFFSET_BITS-1:0]  n_i,
  output logic [4:0]              day_o,
  output logic [3:0]              month_o,
  output logic [8:0]              rem_o,
  output logic [OFFSET_BITS-1:0]  n_o,
  output cdo_pkg::step_ctl_t      ctl_o
);

  logic [4:0]             len;
  logic [OFFSET_BITS:0]   sum;
  logic [OFFSET_BITS-1:0] day_ext;

  assign len     = cdo_pkg::month_len(month_i, cdo_pkg::leap_of(rem_i));
  assign day_ext = OFFSET_BITS'(day_i);
  assign sum     = {1'b0, n_i} + (OFFSET_BITS + 1)'(day_i);

  always_comb begin
    day_o   = day_i;
    month_o = month_i;
    rem_o   = rem_i;
    n_o     = n_i;
    ctl_o   = '0;
    if (!mode_i) begin
      // Forward: finish inside this month or move to day zero of the next
      if (sum <= (OFFSET_BITS + 1)'(len)) begin
        day_o        = sum[4:0];
        ctl_o.finish = 1'b1;
      end else begin
        n_o   = n_i - OFFSET_BITS'(len - day_i);
        day_o = 5'd0;
        if (month_i == cdo_pkg::MONTH_DEC) begin
          month_o        = cdo_pkg::MONTH_JAN;
          rem_o          = (rem_i == cdo_pkg::CYCLE_LAST) ? 9'd0 : rem_i + 9'd1;
          ctl_o.year_inc = 1'b1;
        end else begin
          month_o = month_i + 4'd1;
        end
      end
    end else begin
      // Backward: finish inside this month or move to the end of the previous
      if (day_ext > n_i) begin
        day_o        = day_i - n_i[4:0];
        ctl_o.finish = 1'b1;
      end else begin
        n_o = n_i - day_ext;
        if (month_i == cdo_pkg::MONTH_JAN) begin
          month_o        = cdo_pkg::MONTH_DEC;
          rem_o          = (rem_i == 9'd0) ? cdo_pkg::CYCLE_LAST : rem_i - 9'd1;
          ctl_o.year_dec = 1'b1;
        end else begin
          month_o = month_i - 4'd1;
        end
        day_o = cdo_pkg::month_len(month_o, cdo_pkg::leap_of(rem_o));
      end
    end
  end

endmodule

/* hdl/calendar_date_day_offset_top.sv */
// Gregorian date plus/minus day count: sequencer, walk registers and result register
//
// Usage:
//   Drive in_i and raise start; the transaction is taken at a clock edge where
//   start is high and busy is low. busy stays high until the result is ready.
//   The result appears on result_o for exactly one cycle with done_o high; the
//   receiver must take it in that cycle, there is no back-pressure.
// Operation:
//   The start year is first reduced modulo 400 by repeated trials, then the
//   date is checked, then the walk moves one calendar month per cycle through a
//   single add/compare/subtract unit. One item is in flight at a time; a new
//   start may be given in the cycle done_o is high.
// Flags:
//   bad_input echoes the start date for an invalid date; out_of_range clamps to
//   31 Dec of YEAR_LIMIT or 1 Jan of year 1.
// Reset:
//   rst_ni low clears the sequencer and done_o; busy is low afterwards.
`include "calendar_date_day_offset_top_assert.svh"

module calendar_date_day_offset_top #(
  parameter int OFFSET_BITS = 16,
  parameter int YEAR_LIMIT  = 9999
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cdo_pkg::in_t  in_i,
  output logic          done_o,
  output cdo_pkg::out_t result_o
);

  localparam int YW = $clog2(YEAR_LIMIT + 1);
  localparam int CW = (YW > cdo_pkg::YEAR_W) ? YW : cdo_pkg::YEAR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_WALK
  } state_e;

  state_e                 state_q, state_d;
  cdo_pkg::in_t           in_q, in_d;
  logic [4:0]             day_q, day_d;
  logic [3:0]             month_q, month_d;
  logic [YW-1:0]          year_q, year_d;
  logic [8:0]             rem_q, rem_d;
  logic [OFFSET_BITS-1:0] n_q, n_d;
  logic                   done_q, done_d;
  cdo_pkg::out_t          res_q, res_d;

  logic                   accept;
  logic                   mod_done;
  logic [8:0]             mod_rem;
  logic                   bad;
  logic [4:0]             st_day;
  logic [3:0]             st_month;
  logic [8:0]             st_rem;
  logic [OFFSET_BITS-1:0] st_n;
  cdo_pkg::step_ctl_t     st_ctl;
  logic                   flags_clash;
  logic                   walk_month_ok;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  cdo_year_mod u_year_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (accept),
    .year_i (in_i.start_year),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  cdo_step #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .mode_i  (in_q.mode),
    .day_i   (day_q),
    .month_i (month_q),
    .rem_i   (rem_q),
    .n_i     (n_q),
    .day_o   (st_day),
    .month_o (st_month),
    .rem_o   (st_rem),
    .n_o     (st_n),
    .ctl_o   (st_ctl)
  );

  // Start date validity, evaluated once the year remainder is known
  assign bad = (in_q.start_day == 5'd0) || (in_q.start_month == 4'd0) ||
               (in_q.start_month > cdo_pkg::MONTH_DEC) ||
               (in_q.start_year == '0) ||
               (CW'(in_q.start_year) > CW'(YEAR_LIMIT)) ||
               (in_q.start_day >
                cdo_pkg::month_len(in_q.start_month, cdo_pkg::leap_of(mod_rem)));

  // Sequencer and walk datapath
  always_comb begin
    state_d = state_q;
    in_d    = in_q;
    day_d   = day_q;
    month_d = month_q;
    year_d  = year_q;
    rem_d   = rem_q;
    n_d     = n_q;
    done_d  = 1'b0;
    res_d   = res_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          in_d    = in_i;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          if (bad) begin
            res_d   = '{result_day: in_q.start_day, result_month: in_q.start_month,
                        result_year: in_q.start_year, out_of_range: 1'b0,
                        bad_input: 1'b1};
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            day_d   = in_q.start_day;
            month_d = in_q.start_month;
            year_d  = YW'(in_q.start_year);
            rem_d   = mod_rem;
            n_d     = OFFSET_BITS'(in_q.offset_days);
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (n_q == '0) begin
          res_d   = '{result_day: day_q, result_month: month_q,
                      result_year: cdo_pkg::YEAR_W'(year_q), out_of_range: 1'b0,
                      bad_input: 1'b0};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (st_ctl.year_inc && (year_q == YW'(YEAR_LIMIT))) begin
          // Walked past the last supported year
          res_d   = '{result_day: cdo_pkg::LONG_DAYS, result_month: cdo_pkg::MONTH_DEC,
                      result_year: cdo_pkg::YEAR_W'(YEAR_LIMIT), out_of_range: 1'b1,
                      bad_input: 1'b0};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (st_ctl.year_dec && (year_q == YW'(1))) begin
          // Walked before year one
          res_d   = '{result_day: 5'd1, result_month: cdo_pkg::MONTH_JAN,
                      result_year: cdo_pkg::YEAR_W'(1), out_of_range: 1'b1,
                      bad_input: 1'b0};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (st_ctl.finish) begin
          res_d   = '{result_day: st_day, result_month: month_q,
                      result_year: cdo_pkg::YEAR_W'(year_q), out_of_range: 1'b0,
                      bad_input: 1'b0};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          day_d   = st_day;
          month_d = st_month;
          rem_d   = st_rem;
          n_d     = st_n;
          if (st_ctl.year_inc) begin
            year_d = year_q + YW'(1);
          end else if (st_ctl.year_dec) begin
            year_d = year_q - YW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, walk registers and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      in_q    <= '0;
      day_q   <= '0;
      month_q <= '0;
      year_q  <= '0;
      rem_q   <= '0;
      n_q     <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      in_q    <= in_d;
      day_q   <= day_d;
      month_q <= month_d;
      year_q  <= year_d;
      rem_q   <= rem_d;
      n_q     <= n_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // Terms checked by the assertions below
  assign flags_clash   = result_o.out_of_range && result_o.bad_input;
  assign walk_month_ok = (month_q >= cdo_pkg::MONTH_JAN) && (month_q <= cdo_pkg::MONTH_DEC);

  `CDO_ASSERT_RST(a_reset_quiet, !rst_ni |=> (!busy && !done_o), "busy or done during reset")
  `CDO_ASSERT(a_accept_busy, accept |=> busy, "accepted transaction did not raise busy")
  `CDO_ASSERT(a_single_strobe, done_o |=> !done_o, "result strobe longer than one cycle")
  `CDO_ASSERT(a_flags_exclusive, done_o |-> !flags_clash, "both result flags set")
  `CDO_ASSERT(a_walk_month, (state_q == ST_WALK) |-> walk_month_ok, "walk month out of range")

endmodule

/* test/calendar_date_day_offset_checker.sv */
// Checker for the date offset block: predicts each result date and compares it with the output
`timescale 1ns / 1ps

module calendar_date_day_offset_checker #(
  parameter int OFFSET_BITS = 16,
  parameter int YEAR_LIMIT  = 9999
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  cdo_pkg::in_t  in_i,
  input  logic          done_i,
  input  cdo_pkg::out_t result_i,
  output int            fail_count_o,
  output int            pending_o
);

  // Result dates still owed by the block, oldest first
  cdo_pkg::out_t date_q[$];
  int            txn_seen;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    txn_seen     = 0;
  end

  // Gregorian leap rule
  function automatic bit is_leap(input int y);
    return (y % 4 == 0) && ((y % cdo_pkg::YEAR_CYCLE == 0) || (y % cdo_pkg::CENTURY != 0));
  endfunction

  function automatic int days_in_month(input int m, input int y);
    int len;
    case (m)
      cdo_pkg::MONTH_FEB: len = is_leap(y) ? cdo_pkg::FEB_LEAP_DAYS : cdo_pkg::FEB_DAYS;
      4, 6, 9, 11:        len = cdo_pkg::SHORT_DAYS;
      default:            len = cdo_pkg::LONG_DAYS;
    endcase
    return len;
  endfunction

  // Walk the date month by month, forward or backward
  function automatic cdo_pkg::out_t shift_date(input cdo_pkg::in_t item);
    cdo_pkg::out_t res;
    int            d;
    int            m;
    int            y;
    int            n;
    int            len;
    res = '0;
    d   = item.start_day;
    m   = item.start_month;
    y   = item.start_year;
    n   = int'(item.offset_days) & ((1 << OFFSET_BITS) - 1);

    // Invalid start date is echoed back unchanged
    if (d == 0 || m == 0 || m > cdo_pkg::MONTH_DEC || y == 0 || y > YEAR_LIMIT ||
        d > days_in_month(m, y)) begin
      res.result_day   = item.start_day;
      res.result_month = item.start_month;
      res.result_year  = item.start_year;
      res.bad_input    = 1'b1;
      return res;
    end

    if (!item.mode) begin
      while (n > 0) begin
        len = days_in_month(m, y);
        if (d + n <= len) begin
          d = d + n;
          n = 0;
        end else begin
          n = n - (len - d);
          d = 0;
          if (m == cdo_pkg::MONTH_DEC) begin
            m = cdo_pkg::MONTH_JAN;
            y = y + 1;
            // Ran past the last year: clamp to its final day
            if (y > YEAR_LIMIT) begin
              res.result_day   = cdo_pkg::LONG_DAYS;
              res.result_month = cdo_pkg::MONTH_DEC;
              res.result_year  = cdo_pkg::YEAR_W'(YEAR_LIMIT);
              res.out_of_range = 1'b1;
              return res;
            end
          end else begin
            m = m + 1;
          end
        end
      end
    end else begin
      while (n > 0) begin
        if (d > n) begin
          d = d - n;
          n = 0;
        end else begin
          n = n - d;
          if (m == cdo_pkg::MONTH_JAN) begin
            m = cdo_pkg::MONTH_DEC;
            y = y - 1;
            // Ran before year one: clamp to its first day
            if (y == 0) begin
              res.result_day   = 5'd1;
              res.result_month = cdo_pkg::MONTH_JAN;
              res.result_year  = cdo_pkg::YEAR_W'(1);
              res.out_of_range = 1'b1;
              return res;
            end
          end else begin
            m = m - 1;
          end
          d = days_in_month(m, y);
        end
      end
    end

    res.result_day   = 5'(d);
    res.result_month = 4'(m);
    res.result_year  = cdo_pkg::YEAR_W'(y);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("[%0t] result %0d: %s is %0d, expected %0d", $realtime, txn_seen, field,
             got, want);
    fail_count_o++;
  endtask

  // Results first, so a start in the same cycle as done queues behind the pending one
  always @(posedge clk_i) begin
    cdo_pkg::out_t want;
    if (rst_ni) begin
      if (done_i === 1'b1) begin
        if (date_q.size() == 0) begin
          $display("[%0t] result with no transaction outstanding", $realtime);
          fail_count_o++;
        end else begin
          want = date_q.pop_front();
          if (result_i.result_day !== want.result_day)
            report_mismatch("result_day", result_i.result_day, want.result_day);
          if (result_i.result_month !== want.result_month)
            report_mismatch("result_month", result_i.result_month, want.result_month);
          if (result_i.result_year !== want.result_year)
            report_mismatch("result_year", result_i.result_year, want.result_year);
          if (result_i.out_of_range !== want.out_of_range)
            report_mismatch("out_of_range", result_i.out_of_range, want.out_of_range);
          if (result_i.bad_input !== want.bad_input)
            report_mismatch("bad_input", result_i.bad_input, want.bad_input);
        end
        txn_seen++;
      end
      if (start_i && !busy_i) begin
        date_q.push_back(shift_date(in_i));
      end
      pending_o = date_q.size();
    end
  end

endmodule

/* test/tb_calendar_date_day_offset_top.sv */
// Testbench top for the date offset block: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_calendar_date_day_offset_top;

  localparam int  OFFSET_BITS  = 16;
  localparam int  YEAR_LIMIT   = 9999;
  localparam int  RANDOM_ITEMS = 250;
  localparam int  CYCLE_LIMIT  = 3_000_000;
  localparam int  DRAIN_CYCLES = 32;
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_SUB    = 1'b1;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  cdo_pkg::in_t  in_i;
  logic          done_o;
  cdo_pkg::out_t result_o;
  int            fail_count;
  int            pending;
  int            cycle_count;
  bit            no_idle;

  calendar_date_day_offset_top #(
    .OFFSET_BITS (OFFSET_BITS),
    .YEAR_LIMIT  (YEAR_LIMIT)
  ) uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .in_i     (in_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  calendar_date_day_offset_checker #(
    .OFFSET_BITS (OFFSET_BITS),
    .YEAR_LIMIT  (YEAR_LIMIT)
  ) date_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .in_i         (in_i),
    .done_i       (done_o),
    .result_i     (result_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on total run length
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic cdo_pkg::in_t make_date(input logic mode, input int d, input int m,
                                             input int y, input int n);
    cdo_pkg::in_t item;
    item.mode        = mode;
    item.start_day   = 5'(d);
    item.start_month = 4'(m);
    item.start_year  = 14'(y);
    item.offset_days = 16'(n);
    return item;
  endfunction

  // Any bit pattern, mostly invalid dates
  function automatic cdo_pkg::in_t junk_date();
    return make_date(1'($urandom), $urandom_range(0, 31), $urandom_range(0, 15),
                     $urandom_range(0, 16383), $urandom_range(0, 65535));
  endfunction

  // Plausible date; days past 28 may still be invalid for the month
  function automatic cdo_pkg::in_t plausible_date();
    int d;
    int y;
    int n;
    int pick;
    d = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 28) : $urandom_range(29, 31);
    pick = $urandom_range(0, 9);
    if (pick == 0)      y = $urandom_range(1, 200);
    else if (pick == 1) y = $urandom_range(9800, YEAR_LIMIT);
    else if (pick == 2) y = cdo_pkg::CENTURY * $urandom_range(1, 99);
    else                y = $urandom_range(1, YEAR_LIMIT);
    // Mostly short walks, a few across the whole offset range
    pick = $urandom_range(0, 19);
    if (pick < 12)      n = $urandom_range(0, 400);
    else if (pick < 18) n = $urandom_range(0, 5000);
    else                n = $urandom_range(0, 65535);
    return make_date(1'($urandom), d, $urandom_range(1, 12), y, n);
  endfunction

  // Idle length before the next transaction; no idling inside bursts
  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 19);
    if (no_idle || pick < 9) return 0;
    if (pick < 16)           return $urandom_range(1, 3);
    if (pick < 19)           return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Drive at falling edges, take the transaction when busy is low at a rising edge
  task automatic send_date(input cdo_pkg::in_t item, input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      in_i  <= junk_date();
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_i  <= item;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    in_i    = '0;
    no_idle = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero offset, valid and invalid
    send_date(make_date(MODE_ADD, 15, 6, 2024, 0), idle_gap());
    send_date(make_date(MODE_SUB, 0, 6, 2024, 0), idle_gap());
    // Malformed start dates
    send_date(make_date(MODE_ADD, 10, 0, 2024, 5), idle_gap());
    send_date(make_date(MODE_ADD, 10, 13, 2024, 5), idle_gap());
    send_date(make_date(MODE_SUB, 31, 15, 16383, 65535), idle_gap());
    send_date(make_date(MODE_ADD, 1, 1, 0, 5), idle_gap());
    send_date(make_date(MODE_ADD, 1, 1, YEAR_LIMIT + 1, 5), idle_gap());
    send_date(make_date(MODE_ADD, 31, 4, 2024, 5), idle_gap());
    // February in century and leap years
    send_date(make_date(MODE_ADD, 29, 2, 1900, 1), idle_gap());
    send_date(make_date(MODE_ADD, 29, 2, 2000, 1), idle_gap());
    send_date(make_date(MODE_ADD, 28, 2, 2100, 1), idle_gap());
    send_date(make_date(MODE_SUB, 1, 3, 2000, 1), idle_gap());
    send_date(make_date(MODE_SUB, 1, 3, 1900, 1), idle_gap());
    send_date(make_date(MODE_ADD, 28, 2, 2004, 1), idle_gap());
    // Year rollover both ways
    send_date(make_date(MODE_ADD, 31, 12, 1999, 1), idle_gap());
    send_date(make_date(MODE_SUB, 1, 1, 2000, 1), idle_gap());
    // Edges of the year range, and clamping past them
    send_date(make_date(MODE_ADD, 31, 12, YEAR_LIMIT, 1), idle_gap());
    send_date(make_date(MODE_SUB, 1, 1, 1, 1), idle_gap());
    send_date(make_date(MODE_ADD, 1, 1, 1, 65535), idle_gap());
    send_date(make_date(MODE_SUB, 31, 12, YEAR_LIMIT, 65535), idle_gap());
    send_date(make_date(MODE_ADD, 1, 1, 9900, 65535), idle_gap());
    send_date(make_date(MODE_SUB, 31, 12, 100, 65535), idle_gap());
    // Offset exactly to the end of a month
    send_date(make_date(MODE_ADD, 1, 1, 2023, 30), idle_gap());
    send_date(make_date(MODE_SUB, 31, 1, 2023, 31), idle_gap());
    wait_drained();

    // Random part: mostly plausible dates, some noise, with idle-free bursts
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 99) < 15) send_date(junk_date(), idle_gap());
      else                            send_date(plausible_date(), idle_gap());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0) $display("simulation ok");
    else                 $display("simulation failed");
    $finish;
  end

endmodule
